[rtl/bra_pkg.sv]
// shared constants and types of the bitmap run allocator
`timescale 1ns / 1ps
package bra_pkg;

    localparam int MAP_BYTES = 128;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 10;
    localparam int RUN_W     = 11;
    localparam int OP_W      = 2;

    typedef logic [7:0]        t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_TEST  = 2'd1,
        OP_WRITE = 2'd2,
        OP_SCAN  = 2'd3
    } t_op;

    // control from the sequencer to the run scanner
    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

    // status from the run scanner back to the sequencer
    typedef struct packed {
        logic       hit;
        logic [2:0] pos;
    } t_scan_res;

endpackage

[rtl/bra_map_ram.sv]
// allocation map storage: one byte per row, valid bits give the cleared state
`timescale 1ns / 1ps
module bra_map_ram (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  bra_pkg::t_addr        i_wr_addr,
    input  bra_pkg::t_byte        i_wr_data,
    input  logic                  i_rd_en,
    input  bra_pkg::t_addr        i_rd_addr,
    output bra_pkg::t_byte        o_rd_data,
    input  logic                  i_clr_en,
    input  logic [bra_pkg::CNT_W-1:0] i_clr_bytes
);
    import bra_pkg::*;

    t_byte                r_mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] r_valid;
    t_byte                r_rd_raw;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_clr_en) begin
                // drop only the rows in use
                for (int k = 0; k < MAP_BYTES; k++) begin
                    if (CNT_W'(k) < i_clr_bytes) begin
                        r_valid[k] <= 1'b0;
                    end
                end
            end
        end
    end

    // a row never written since its last clear reads as all free
    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

[rtl/bra_run_scan.sv]
// run scanner: takes one map byte per cycle while step is set and tracks the current free run
`timescale 1ns / 1ps
module bra_run_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bra_pkg::t_scan_ctl        i_ctl,
    input  bra_pkg::t_byte            i_digit,
    input  logic [bra_pkg::RUN_W-1:0] i_len,
    output bra_pkg::t_scan_res        o_res
);
    import bra_pkg::*;

    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] n_run;
    t_scan_res        res;

    always_comb begin
        n_run   = r_run;
        res.hit = 1'b0;
        res.pos = '0;
        // eight bit steps, lowest bit first
        for (int k = 0; k < 8; k++) begin
            if (i_digit[k]) begin
                n_run = '0;
            end else begin
                n_run = n_run + RUN_W'(1);
            end
            if (!res.hit && n_run == i_len) begin
                res.hit = 1'b1;
                res.pos = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_ctl.start) begin
            r_run <= '0;
        end else if (i_ctl.step) begin
            r_run <= n_run;
        end
    end

    assign o_res = res;

endmodule

[rtl/bitmap_run_allocator.sv]
// top level: request sequencer, configuration register and result register
`timescale 1ns / 1ps
// Keeps a page bitmap of up to 1024 bits (128 bytes, bit i in byte i/8 at position i%8)
// and serves one request at a time: clear all, test a bit, write a bit, or scan for the
// lowest run of free bits. Clear and out-of-range requests go from start to done, test
// and write pass a read-modify-write state (read, then modify and write back), and a scan
// walks the map one byte per cycle through the read port, eight bits handled per byte.
// Reset needs no clearing pass: the map comes out of reset all free. A finished result
// waits in the output register while the next request is taken. The user must write
// bytes_in_use only while no request is in flight; the block itself does not enforce it.
module bitmap_run_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bra_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bra_pkg::OP_W-1:0]  i_op,
    input  logic [bra_pkg::IDX_W-1:0] i_bit_index,
    input  logic                      i_set_value,
    input  logic [bra_pkg::RUN_W-1:0] i_run_length,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [bra_pkg::IDX_W-1:0] o_start_index,
    output logic                      o_bit_value
);
    import bra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RMW,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_bytes;
    t_op              r_op;
    logic [IDX_W-1:0] r_idx;
    logic             r_val;
    logic [RUN_W-1:0] r_len;
    t_addr            r_cons, n_cons;
    logic             r_out_valid, n_out_valid;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_start, n_start;
    logic             r_bit_value, n_bit_value;
    logic             r_res_found, n_res_found;
    logic [IDX_W-1:0] r_res_start, n_res_start;
    logic             r_res_bit, n_res_bit;

    logic             accept;
    logic [CNT_W-1:0] nbytes;
    logic [RUN_W-1:0] map_bits;
    logic             idx_ok;
    logic             ram_wr_en;
    t_byte            ram_wr_data;
    logic             ram_rd_en;
    t_addr            ram_rd_addr;
    t_byte            ram_rd_data;
    logic             ram_clr_en;
    t_scan_ctl        scan_ctl;
    t_scan_res        scan_res;
    logic [IDX_W-1:0] hit_bit;
    logic [RUN_W-1:0] hit_start;
    logic             last_byte;
    logic             out_free;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign nbytes     = (r_bytes > CNT_W'(MAP_BYTES)) ? CNT_W'(MAP_BYTES) : r_bytes;
    assign map_bits   = {nbytes, 3'b000};
    assign idx_ok     = CNT_W'(r_idx[IDX_W-1:3]) < nbytes;
    assign hit_bit    = {r_cons, scan_res.pos};
    assign hit_start  = {1'b0, hit_bit} + RUN_W'(1) - r_len;
    assign last_byte  = (CNT_W'(r_cons) + CNT_W'(1)) == nbytes;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        ram_wr_data               = ram_rd_data;
        ram_wr_data[r_idx[2:0]]   = r_val;
    end

    always_comb begin
        n_state      = r_state;
        n_cons       = r_cons;
        n_out_valid  = r_out_valid;
        n_found      = r_found;
        n_start      = r_start;
        n_bit_value  = r_bit_value;
        n_res_found  = r_res_found;
        n_res_start  = r_res_start;
        n_res_bit    = r_res_bit;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_idx[IDX_W-1:3];
        ram_clr_en   = 1'b0;
        scan_ctl     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_res_found = 1'b0;
                n_res_start = '0;
                n_res_bit   = 1'b0;
                n_state     = S_DONE;
                case (r_op)
                    OP_CLEAR: begin
                        ram_clr_en  = 1'b1;
                        n_res_found = 1'b1;
                    end
                    OP_TEST, OP_WRITE: begin
                        if (idx_ok) begin
                            ram_rd_en = 1'b1;
                            n_state   = S_RMW;
                        end
                    end
                    OP_SCAN: begin
                        if (r_len != '0 && r_len <= map_bits) begin
                            ram_rd_en      = 1'b1;
                            ram_rd_addr    = '0;
                            n_cons         = '0;
                            scan_ctl.start = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RMW: begin
                n_res_found = 1'b1;
                if (r_op == OP_TEST) begin
                    n_res_bit = ram_rd_data[r_idx[2:0]];
                end else begin
                    ram_wr_en = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // consume byte r_cons while fetching the next one
                scan_ctl.step = 1'b1;
                ram_rd_en     = 1'b1;
                ram_rd_addr   = r_cons + t_addr'(1);
                n_cons        = r_cons + t_addr'(1);
                if (scan_res.hit) begin
                    n_res_found = 1'b1;
                    n_res_start = hit_start[IDX_W-1:0];
                    n_state     = S_DONE;
                end else if (last_byte) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_start     = r_res_start;
                    n_bit_value = r_res_bit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bytes     <= CNT_W'(MAP_BYTES);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_bytes <= i_cfg_data;
            end
        end
        if (accept) begin
            r_op  <= t_op'(i_op);
            r_idx <= i_bit_index;
            r_val <= i_set_value;
            r_len <= i_run_length;
        end
        r_cons      <= n_cons;
        r_found     <= n_found;
        r_start     <= n_start;
        r_bit_value <= n_bit_value;
        r_res_found <= n_res_found;
        r_res_start <= n_res_start;
        r_res_bit   <= n_res_bit;
    end

    bra_map_ram u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (ram_wr_en),
        .i_wr_addr  (r_idx[IDX_W-1:3]),
        .i_wr_data  (ram_wr_data),
        .i_rd_en    (ram_rd_en),
        .i_rd_addr  (ram_rd_addr),
        .o_rd_data  (ram_rd_data),
        .i_clr_en   (ram_clr_en),
        .i_clr_bytes(nbytes)
    );

    bra_run_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (scan_ctl),
        .i_digit(ram_rd_data),
        .i_len  (r_len),
        .o_res  (scan_res)
    );

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_start_index = r_start;
    assign o_bit_value   = r_bit_value;

`ifndef SYNTHESIS
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not loaded into output register");

    a_no_start_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_start == '0 && !r_bit_value))
        else $error("result fields set without a hit");

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_cons) < nbytes))
        else $error("scan walked past the bytes in use");

    a_map_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (idx_ok && r_op == OP_WRITE))
        else $error("map written outside a valid write request");
`endif

endmodule

[dv/tb_bitmap_run_allocator.sv]
// self-checking testbench for the bitmap run allocator
`timescale 1ns / 1ps
module tb_bitmap_run_allocator;
    import bra_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 140;
    localparam int CFG_QUIET      = 4;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] start;
        logic             bitv;
    } t_alloc_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_op = OP_CLEAR;
    logic [IDX_W-1:0]  i_bit_index = '0;
    logic              i_set_value = 1'b0;
    logic [RUN_W-1:0]  i_run_length = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_found;
    logic [IDX_W-1:0]  o_start_index;
    logic              o_bit_value;

    // predictor state: page map and byte count register
    logic [7:0]        page_map [0:MAP_BYTES-1];
    logic [CNT_W-1:0]  pages_cfg = 8'd128;
    t_alloc_result     pending_results[$];

    int send_idle_pct = 20;
    int recv_stall_pct = 48;
    int mismatches = 0;
    int sent_items = 0;
    int results_seen = 0;
    int scan_hits = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;

    bitmap_run_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_bit_index   (i_bit_index),
        .i_set_value   (i_set_value),
        .i_run_length  (i_run_length),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_start_index (o_start_index),
        .o_bit_value   (o_bit_value)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned live_bytes();
        int unsigned n;
        n = pages_cfg;
        if (n > MAP_BYTES) begin
            n = MAP_BYTES;
        end
        return n;
    endfunction

    // applies one request to the predicted map and returns the expected result
    function automatic t_alloc_result map_request(input logic [OP_W-1:0] op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic val,
                                                  input logic [RUN_W-1:0] len);
        t_alloc_result r;
        int unsigned   total;
        int unsigned   run;
        r = '0;
        total = live_bytes() * 8;
        run = 0;
        case (op)
            OP_CLEAR: begin
                for (int unsigned b = 0; b < live_bytes(); b++) begin
                    page_map[b] = 8'h00;
                end
                r.found = 1'b1;
            end
            OP_TEST: begin
                if (idx < total) begin
                    r.found = 1'b1;
                    r.bitv = page_map[idx >> 3][idx[2:0]];
                end
            end
            OP_WRITE: begin
                if (idx < total) begin
                    page_map[idx >> 3][idx[2:0]] = val;
                    r.found = 1'b1;
                end
            end
            default: begin
                if (len != 0 && len <= total) begin
                    for (int unsigned i = 0; i < total; i++) begin
                        run = page_map[i >> 3][i % 8] ? 0 : run + 1;
                        if (run == len) begin
                            r.found = 1'b1;
                            r.start = IDX_W'(i + 1 - len);
                            break;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // one request transfer; hands back the predicted result
    task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic val, input logic [RUN_W-1:0] len,
                            output t_alloc_result res);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = op;
        i_bit_index = idx;
        i_set_value = val;
        i_run_length = len;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        res = map_request(op, idx, val, len);
        pending_results.push_back(res);
        sent_items++;
        if (op == OP_SCAN && res.found) begin
            scan_hits++;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (CFG_QUIET) @(negedge i_clk);
    endtask

    task automatic write_bytes_in_use(input logic [CNT_W-1:0] v);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pages_cfg = v;
        cfg_writes++;
    endtask

    task automatic test_full_map_basics();
        t_alloc_result r;
        send_req(OP_TEST, 10'd0, 1'b0, 11'd0, r);
        send_req(OP_TEST, 10'd1023, 1'b1, 11'd2047, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd0, r);
        send_req(OP_SCAN, 10'd1023, 1'b1, 11'd1, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd1024, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd1025, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd2047, r);
        send_req(OP_WRITE, 10'd1023, 1'b1, 11'd0, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd1024, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd1023, r);
        send_req(OP_WRITE, 10'd0, 1'b1, 11'd0, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd1, r);
        send_req(OP_WRITE, 10'd512, 1'b1, 11'd0, r);
        // free runs lie between bits 0 and 512 and between bits 512 and 1023
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd511, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd512, r);
        send_req(OP_CLEAR, 10'd0, 1'b0, 11'd0, r);
        send_req(OP_TEST, 10'd512, 1'b0, 11'd0, r);
    endtask

    task automatic test_register_limits();
        t_alloc_result r;
        send_req(OP_WRITE, 10'd100, 1'b1, 11'd0, r);
        send_req(OP_WRITE, 10'd3, 1'b1, 11'd0, r);
        write_bytes_in_use(8'd1);
        send_req(OP_WRITE, 10'd8, 1'b1, 11'd0, r);
        send_req(OP_TEST, 10'd7, 1'b0, 11'd0, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd8, r);
        // clear only touches byte 0 here, bit 100 must survive
        send_req(OP_CLEAR, 10'd0, 1'b0, 11'd0, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd8, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd9, r);
        write_bytes_in_use(8'd0);
        send_req(OP_TEST, 10'd0, 1'b0, 11'd0, r);
        send_req(OP_WRITE, 10'd0, 1'b1, 11'd0, r);
        send_req(OP_SCAN, 10'd0, 1'b0, 11'd1, r);
        send_req(OP_CLEAR, 10'd0, 1'b0, 11'd0, r);
        write_bytes_in_use(8'd255);
        send_req(OP_TEST, 10'd100, 1'b0, 11'd0, r);
        send_req(OP_TEST, 10'd1023, 1'b0, 11'd0, r);
    endtask

    // mostly allocate and free sequences, with tests, stray writes and noise
    task automatic run_traffic(input int n_items);
        t_alloc_result r;
        int unsigned   target;
        int unsigned   pick;
        int unsigned   total;
        int unsigned   len;
        int unsigned   base;
        target = sent_items + n_items;
        total = live_bytes() * 8;
        while (sent_items < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
                send_req(OP_SCAN, IDX_W'($urandom), 1'($urandom), RUN_W'(len), r);
                if (r.found) begin
                    base = r.start;
                    for (int unsigned k = 0; k < len; k++) begin
                        send_req(OP_WRITE, IDX_W'(base + k), 1'b1, RUN_W'($urandom), r);
                    end
                end
            end else if (pick < 60) begin
                base = $urandom_range(total - 1);
                len = $urandom_range(1, 8);
                for (int unsigned k = 0; k < len; k++) begin
                    send_req(OP_WRITE, IDX_W'(base + k), 1'b0, RUN_W'($urandom), r);
                end
            end else if (pick < 75) begin
                base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(total - 1);
                send_req(OP_TEST, IDX_W'(base), 1'($urandom), RUN_W'($urandom), r);
            end else if (pick < 85) begin
                base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(total - 1);
                send_req(OP_WRITE, IDX_W'(base), 1'($urandom), RUN_W'($urandom), r);
            end else if (pick < 95) begin
                len = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 24);
                send_req(OP_SCAN, IDX_W'($urandom), 1'($urandom), RUN_W'(len), r);
            end else if (pick < 97) begin
                send_req(OP_CLEAR, IDX_W'($urandom), 1'($urandom), RUN_W'($urandom), r);
            end else begin
                send_req(OP_W'($urandom), IDX_W'($urandom), 1'($urandom),
                         RUN_W'($urandom), r);
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 20;
        recv_stall_pct = 48;
        write_bytes_in_use(8'd128);
        run_traffic(210);
        write_bytes_in_use(8'd1);
        run_traffic(210);
        send_idle_pct = 48;
        recv_stall_pct = 20;
        write_bytes_in_use(CNT_W'($urandom_range(1, 128)));
        run_traffic(210);
        write_bytes_in_use(8'd16);
        run_traffic(210);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_bytes_in_use(8'd255);
        run_traffic(210);
        write_bytes_in_use(CNT_W'($urandom_range(1, 128)));
        run_traffic(200);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    mismatches++;
                end
                if (o_start_index !== want.start) begin
                    $error("start_index: expected %0d, got %0d", want.start, o_start_index);
                    mismatches++;
                end
                if (o_bit_value !== want.bitv) begin
                    $error("bit_value: expected %0d, got %0d", want.bitv, o_bit_value);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        foreach (page_map[b]) begin
            page_map[b] = 8'h00;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_full_map_basics();
        test_register_limits();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d scans hit a free run",
                 sent_items, results_seen, scan_hits);
        $display("%0d byte count writes, from zero and one byte up to the capped maximum",
                 cfg_writes);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bra_pkg.sv
rtl/bra_map_ram.sv
rtl/bra_run_scan.sv
rtl/bitmap_run_allocator.sv
dv/tb_bitmap_run_allocator.sv
